// ----- hdl/rbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rbf_pkg: shared types and constants of the RBF neuron unit
// Command codes, register indexes, fixed-point constants and the job record
// that travels from the accumulate front end to the activation back end.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

    localparam int NUM_INPUTS  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int ACC_W = 40;

    // command codes
    localparam logic [1:0] CMD_LOAD_CENTER = 2'd0;
    localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_ELEMENT     = 2'd2;
    localparam logic [1:0] CMD_RESERVED    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_WIDTH_SCALE = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD   = 2'd2;

    localparam logic        MODE_GAUSSIAN   = 1'b0;
    localparam logic        MODE_SIGMOID    = 1'b1;
    localparam logic [14:0] WIDTH_SCALE_RST = 15'd4096;

    // exp(-1/16) in Q0.30, and rounding half
    localparam logic [29:0] EXP_STEP = 30'd1008687096;
    localparam logic [30:0] Q30_ONE  = 31'd1073741824;
    localparam logic [29:0] Q30_HALF = 30'd536870912;
    // 24.0 in Q16.16: exponent argument beyond this gives zero
    localparam logic [20:0] EXP_CUT_Z = 21'd1572864;
    // ceil(2^18 / 6), reciprocal for the cubic term
    localparam logic [15:0] RECIP_6 = 16'd43691;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    mode;
    } t_job;

endpackage

`default_nettype wire

// ----- hdl/rbf_front.sv -----
// ----------------------------------------------------------------------------
// rbf_front: load handling and streaming accumulation
// Writes center/weight entries, forms the distance or weighted term of each
// element through a three-stage pipeline and pushes a job on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_front #(
    parameter int NUM_INPUTS  = rbf_pkg::NUM_INPUTS,
    parameter int QUEUE_DEPTH = rbf_pkg::QUEUE_DEPTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [1:0]                    i_cmd,
    input  wire  [3:0]                    i_index,
    input  wire  [15:0]                   i_value,
    input  wire                           i_last,
    input  wire                           i_mode,
    input  wire  [$clog2(QUEUE_DEPTH+1)-1:0] i_q_count,
    output logic                          o_push,
    output rbf_pkg::t_job                 o_job
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int SW = CW + 2;

    logic [15:0] r_centers [16];
    logic [15:0] r_weights [16];

    logic               r1_valid, r1_last, r1_mode;
    logic signed [16:0] r1_a, r1_b;
    logic               r2_valid, r2_last, r2_mode;
    logic signed [33:0] r2_prod;
    logic signed [rbf_pkg::ACC_W-1:0] r_acc;

    logic               accept;
    logic               elem_ok;
    logic signed [16:0] x_ext, c_ext, w_ext, diff;
    logic signed [16:0] n_a, n_b;
    logic [SW-1:0]      inflight;
    logic signed [rbf_pkg::ACC_W:0]   sum;
    logic signed [rbf_pkg::ACC_W-1:0] sat;

    // room in the queue for every last element already in the pipe
    assign inflight = SW'(i_q_count) + SW'(r1_valid & r1_last) + SW'(r2_valid & r2_last);
    assign o_ready  = inflight < SW'(QUEUE_DEPTH);
    assign accept   = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == rbf_pkg::CMD_LOAD_CENTER) begin
            r_centers[i_index] <= i_value;
        end
        if (accept && i_cmd == rbf_pkg::CMD_LOAD_WEIGHT) begin
            r_weights[i_index] <= i_value;
        end
    end

    always_comb begin
        x_ext   = {i_value[15], i_value};
        c_ext   = {r_centers[i_index][15], r_centers[i_index]};
        w_ext   = {r_weights[i_index][15], r_weights[i_index]};
        diff    = x_ext - c_ext;
        elem_ok = (i_cmd == rbf_pkg::CMD_ELEMENT) &&
                  ({5'd0, i_index} < 9'(NUM_INPUTS));
        n_a = '0;
        n_b = '0;
        if (elem_ok) begin
            if (i_mode == rbf_pkg::MODE_GAUSSIAN) begin
                n_a = diff;
                n_b = diff;
            end else if (i_index != 4'd0) begin
                n_a = w_ext;
                n_b = x_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
        r1_last <= (i_cmd == rbf_pkg::CMD_ELEMENT) & i_last;
        r1_mode <= i_mode;
        r1_a    <= n_a;
        r1_b    <= n_b;
        r2_last <= r1_last;
        r2_mode <= r1_mode;
        r2_prod <= r1_a * r1_b;
    end

    // saturating accumulate
    always_comb begin
        sum = {r_acc[rbf_pkg::ACC_W-1], r_acc} + {{7{r2_prod[33]}}, r2_prod};
        if (sum[rbf_pkg::ACC_W] != sum[rbf_pkg::ACC_W-1]) begin
            sat = sum[rbf_pkg::ACC_W] ? {1'b1, {(rbf_pkg::ACC_W-1){1'b0}}}
                                      : {1'b0, {(rbf_pkg::ACC_W-1){1'b1}}};
        end else begin
            sat = sum[rbf_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r2_valid) begin
            r_acc <= r2_last ? '0 : sat;
        end
    end

    assign o_push    = r2_valid & r2_last;
    assign o_job.acc = sat;
    assign o_job.mode = r2_mode;

endmodule

`default_nettype wire

// ----- hdl/rbf_queue.sv -----
// ----------------------------------------------------------------------------
// rbf_queue: job queue between front and back end
// Small register FIFO of accumulated sums awaiting activation.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_queue #(
    parameter int QUEUE_DEPTH = rbf_pkg::QUEUE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_push,
    input  rbf_pkg::t_job                    i_job,
    input  wire                              i_pop,
    output rbf_pkg::t_job                    o_job,
    output logic                             o_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    rbf_pkg::t_job r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          pop;

    assign pop     = i_pop & (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH-1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH-1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rbf_back.sv -----
// ----------------------------------------------------------------------------
// rbf_back: activation sequencer
// Takes a job, runs the shared restoring divider and the exponential
// (cubic series, then one multiply by exp(-1/16) per step) and loads the
// output register; past the cutoff a gaussian job skips both, a sigmoid the exp.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rbf_pkg::t_job      i_job,
    input  wire                i_q_empty,
    output logic               o_pop,
    input  wire  [14:0]        i_width_scale,
    input  wire  [15:0]        i_threshold,
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    output logic [15:0]        o_m_tdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_G_SQ  = 4'd1;
    localparam logic [3:0] S_G_CMP = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_E_R2  = 4'd4;
    localparam logic [3:0] S_E_R3  = 4'd5;
    localparam logic [3:0] S_E_D6  = 4'd6;
    localparam logic [3:0] S_E_FIX = 4'd7;
    localparam logic [3:0] S_E_ML  = 4'd8;
    localparam logic [3:0] S_E_MH  = 4'd9;
    localparam logic [3:0] S_E_MS  = 4'd10;
    localparam logic [3:0] S_S_DEN = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]  r_state;
    logic        r_mode, r_neg;
    logic [38:0] r_d2;
    logic [31:0] r_den, r_rem;
    logic [20:0] r_q, r_z;
    logic [4:0]  r_cnt;
    logic [21:0] r_r2;
    logic [17:0] r_r3;
    logic [15:0] r_q6;
    logic [30:0] r_v;
    logic [8:0]  r_m;
    logic [45:0] r_plo;
    logic [44:0] r_phi;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic [38:0] d2;
    logic [40:0] s_sum, mag;
    logic [32:0] arg;
    logic [14:0] s_eff;
    logic [29:0] ss;
    logic [38:0] den24;
    logic [32:0] rem2;
    logic        ge;
    logic [31:0] new_rem;
    logic [20:0] new_q;
    logic [25:0] r_frac;
    logic [51:0] p_r2;
    logic [47:0] p_r3;
    logic [33:0] p_d6;
    logic [18:0] q6x6;
    logic [15:0] q6c;
    logic [30:0] v_init;
    logic [60:0] m_sum;
    logic [31:0] s_den;
    logic [46:0] s_num;
    logic [30:0] g_rnd;
    logic [15:0] act;
    logic [3:0]  post_exp;
    logic        out_load;

    always_comb begin
        d2    = i_job.acc[rbf_pkg::ACC_W-1] ? '0 : i_job.acc[38:0];
        s_sum = {i_job.acc[rbf_pkg::ACC_W-1], i_job.acc} +
                {{13{i_threshold[15]}}, i_threshold, 12'd0};
        mag   = s_sum[40] ? (~s_sum + 41'd1) : s_sum;
        arg   = mag[40:8];
        s_eff = (i_width_scale == '0) ? 15'd1 : i_width_scale;
        ss    = s_eff * s_eff;
        den24 = {3'd0, r_den, 4'd0} + {4'd0, r_den, 3'd0};
        rem2    = {r_rem, r_q[20]};
        ge      = rem2 >= {1'b0, r_den};
        new_rem = ge ? 32'(rem2 - {1'b0, r_den}) : rem2[31:0];
        new_q   = {r_q[19:0], ge};
        r_frac  = {r_z[11:0], 14'd0};
        p_r2    = r_frac * r_frac;
        p_r3    = r_r2 * r_frac;
        p_d6    = r_r3 * rbf_pkg::RECIP_6;
        q6x6    = {1'b0, r_q6, 2'd0} + {2'd0, r_q6, 1'b0};
        q6c     = (q6x6 > {1'b0, r_r3}) ? r_q6 - 16'd1 : r_q6;
        v_init  = rbf_pkg::Q30_ONE - 31'(r_frac) + 31'(r_r2[21:1]) - 31'(q6c);
        m_sum   = {r_phi, 16'd0} + 61'(r_plo) + 61'(rbf_pkg::Q30_HALF);
        s_den   = 32'(rbf_pkg::Q30_ONE) + 32'(r_v);
        s_num   = (r_neg ? {r_v, 16'd0} : {1'b1, 46'd0}) + 47'(s_den[31:1]);
        g_rnd   = r_v + 31'd8192;
        if (r_mode == rbf_pkg::MODE_GAUSSIAN) begin
            act = g_rnd[30] ? 16'hFFFF : g_rnd[29:14];
        end else begin
            act = r_q[16] ? 16'hFFFF : r_q[15:0];
        end
        post_exp = (r_mode == rbf_pkg::MODE_GAUSSIAN) ? S_OUT : S_S_DEN;
    end

    assign o_pop    = (r_state == S_IDLE) & ~i_q_empty;
    assign out_load = (r_state == S_OUT) & (~r_out_valid | i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_job.mode == rbf_pkg::MODE_GAUSSIAN) begin
                            r_state <= S_G_SQ;
                        end else if (arg >= 33'(rbf_pkg::EXP_CUT_Z)) begin
                            r_state <= S_S_DEN;
                        end else begin
                            r_state <= S_E_R2;
                        end
                    end
                end
                S_G_SQ:  r_state <= S_G_CMP;
                S_G_CMP: r_state <= (r_d2 >= den24) ? S_OUT : S_DIV;
                S_DIV: begin
                    if (r_cnt == 5'd1) begin
                        r_state <= (r_mode == rbf_pkg::MODE_GAUSSIAN) ? S_E_R2 : S_OUT;
                    end
                end
                S_E_R2:  r_state <= S_E_R3;
                S_E_R3:  r_state <= S_E_D6;
                S_E_D6:  r_state <= S_E_FIX;
                S_E_FIX: r_state <= (r_z[20:12] == '0) ? post_exp : S_E_ML;
                S_E_ML:  r_state <= S_E_MH;
                S_E_MH:  r_state <= S_E_MS;
                S_E_MS:  r_state <= (r_m == 9'd1) ? post_exp : S_E_ML;
                S_S_DEN: r_state <= S_DIV;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mode <= i_job.mode;
                r_d2   <= d2;
                r_neg  <= s_sum[40];
                r_z    <= arg[20:0];
                r_v    <= '0;
            end
            S_G_SQ: r_den <= {1'b0, ss, 1'b0};
            S_G_CMP: begin
                r_v   <= '0;
                r_rem <= r_d2[36:5];
                r_q   <= {r_d2[4:0], 16'd0};
                r_cnt <= 5'd21;
            end
            S_DIV: begin
                r_rem <= new_rem;
                r_q   <= new_q;
                r_cnt <= r_cnt - 5'd1;
                r_z   <= new_q;
            end
            S_E_R2: r_r2 <= p_r2[51:30];
            S_E_R3: r_r3 <= p_r3[47:30];
            S_E_D6: r_q6 <= p_d6[33:18];
            S_E_FIX: begin
                r_v <= v_init;
                r_m <= r_z[20:12];
            end
            S_E_ML: r_plo <= r_v[15:0] * rbf_pkg::EXP_STEP;
            S_E_MH: r_phi <= r_v[30:16] * rbf_pkg::EXP_STEP;
            S_E_MS: begin
                r_v <= m_sum[60:30];
                r_m <= r_m - 9'd1;
            end
            S_S_DEN: begin
                r_den <= s_den;
                r_rem <= {2'd0, s_num[46:17]};
                r_q   <= {s_num[16:0], 4'd0};
                r_cnt <= 5'd17;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= act;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- hdl/rbf_neuron_unit.sv -----
// ----------------------------------------------------------------------------
// rbf_neuron_unit: streamed gaussian / sigmoid RBF neuron
// Channel  Dir  Content
// s_*      in   tdata[1:0] cmd, [5:2] index, [21:6] value; tlast = last
// m_*      out  tdata[15:0] activation (Q0.16)
// cfg_*    in   write port: 0 mode, 1 width_scale, 2 threshold
// Elements are taken one per cycle while the job queue has room; a sum is
// queued once its last element has passed the operand and product registers.
// The back end runs one job at a time: a 21-step (gaussian) or 17-step (sigmoid)
// serial divide and up to 383 exp steps, each a multiply low, high and sum.
// A held output stalls the back end, then the queue, then s_tready.
// Synchronous active-low reset clears accumulator, queue, state and config.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_neuron_unit #(
    parameter int NUM_INPUTS  = rbf_pkg::NUM_INPUTS,
    parameter int QUEUE_DEPTH = rbf_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // cmd[1:0], index[5:2], value[21:6], zero pad
    input  wire         i_s_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // activation[15:0]
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    logic        r_mode;
    logic [14:0] r_width_scale;
    logic [15:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rbf_pkg::MODE_GAUSSIAN;
            r_width_scale <= rbf_pkg::WIDTH_SCALE_RST;
            r_threshold   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbf_pkg::CFG_MODE:        r_mode        <= i_cfg_data[0];
                rbf_pkg::CFG_WIDTH_SCALE: r_width_scale <= i_cfg_data[14:0];
                rbf_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                                    push, pop, q_empty;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]        q_count;
    rbf_pkg::t_job                           job_in, job_out;

    rbf_front #(.NUM_INPUTS(NUM_INPUTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_cmd     (i_s_tdata[1:0]),
        .i_index   (i_s_tdata[5:2]),
        .i_value   (i_s_tdata[21:6]),
        .i_last    (i_s_tlast),
        .i_mode    (r_mode),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (job_in)
    );

    rbf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    rbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_out),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .i_width_scale (r_width_scale),
        .i_threshold   (r_threshold),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

`default_nettype wire
